>>> hw/rtl/m68kie_pkg.sv
package m68kie_pkg;

    // Number of interrupt levels, each with its own queue (levels 1 to 7).
    localparam int LevelCount = 7;
    localparam int QueueDepthDefault = 8;

    localparam logic [2:0] LevelNmi = 3'd7;

    // Status register layout and reset value.
    localparam logic [15:0] SrResetValue = 16'h2700;
    localparam logic [15:0] SrMaskBits = 16'h0700;
    localparam logic [15:0] SrSupervisor = 16'h2000;
    localparam int SrSBit = 13;
    localparam int SrMaskLsb = 8;

    // Exception stack frame: PC (32 bits) above the old SR (16 bits).
    localparam logic [31:0] FrameSize = 32'd6;
    localparam logic [31:0] PcSlotOffset = 32'd2;

    // Request opcodes.
    localparam logic [1:0] OpRaise = 2'd0;
    localparam logic [1:0] OpService = 2'd1;
    localparam logic [1:0] OpWriteSr = 2'd2;
    localparam logic [1:0] OpWriteSp = 2'd3;

    // Memory access kinds on the result channel.
    localparam logic [1:0] AccNone = 2'd0;
    localparam logic [1:0] AccWrite32 = 2'd1;
    localparam logic [1:0] AccWrite16 = 2'd2;
    localparam logic [1:0] AccRead32 = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  irq_level;
        logic [7:0]  vector_number;
        logic [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  access_kind;
        logic [31:0] access_address;
        logic [31:0] access_data;
        logic [15:0] status_out;
        logic [31:0] stack_pointer_out;
        logic        interrupt_pending;
        logic        queue_overflow;
        logic        accepted;
        logic        last_result;
    } out_item_t;

    // Commands from the sequencer to the level queues.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] level;
        logic [7:0] push_vector;
    } q_ctrl_t;

    // Queue status seen by the sequencer.
    typedef struct packed {
        logic       any_pending;
        logic       top_valid;
        logic [2:0] top_level;
        logic       push_full;
    } q_stat_t;

    // Microprogram.
    typedef logic [3:0] upc_t;

    typedef enum logic [2:0] {
        EX_NONE,
        EX_RAISE,
        EX_SERVICE,
        EX_WR_SR,
        EX_WR_SP
    } exec_op_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_PLAIN,
        EM_PC,
        EM_SR,
        EM_VEC
    } emit_op_t;

    typedef enum logic [1:0] {
        SQ_GOTO,
        SQ_DISPATCH,
        SQ_BR_TOOK
    } seq_op_t;

    typedef struct packed {
        exec_op_t exec;
        emit_op_t emit;
        logic     last;
        seq_op_t  seq;
        upc_t     target;
    } ucode_t;

    localparam upc_t UpcFetch = 4'd0;
    localparam upc_t UpcRaise = 4'd1;
    localparam upc_t UpcService = 4'd2;
    localparam upc_t UpcWriteSr = 4'd3;
    localparam upc_t UpcWriteSp = 4'd4;
    localparam upc_t UpcEmitDone = 4'd5;
    localparam upc_t UpcEmitPc = 4'd6;
    localparam upc_t UpcEmitSr = 4'd7;
    localparam upc_t UpcEmitVec = 4'd8;

    // The fetch step dispatches to UpcRaise plus the opcode, so the four
    // execute steps must keep the order of the opcodes.
    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t w;
        w.exec = EX_NONE;
        w.emit = EM_NONE;
        w.last = 1'b0;
        w.seq = SQ_GOTO;
        w.target = UpcFetch;
        unique case (upc)
            UpcFetch: begin
                w.seq = SQ_DISPATCH;
                w.target = UpcRaise;
            end
            UpcRaise: begin
                w.exec = EX_RAISE;
                w.target = UpcEmitDone;
            end
            UpcService: begin
                w.exec = EX_SERVICE;
                w.seq = SQ_BR_TOOK;
                w.target = UpcEmitDone;
            end
            UpcWriteSr: begin
                w.exec = EX_WR_SR;
                w.target = UpcEmitDone;
            end
            UpcWriteSp: begin
                w.exec = EX_WR_SP;
                w.target = UpcEmitDone;
            end
            UpcEmitDone: begin
                w.emit = EM_PLAIN;
                w.last = 1'b1;
                w.target = UpcFetch;
            end
            UpcEmitPc: begin
                w.emit = EM_PC;
                w.target = UpcEmitSr;
            end
            UpcEmitSr: begin
                w.emit = EM_SR;
                w.target = UpcEmitVec;
            end
            UpcEmitVec: begin
                w.emit = EM_VEC;
                w.last = 1'b1;
                w.target = UpcFetch;
            end
            default: begin
                w.target = UpcFetch;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/m68k_interrupt_entry_unit_core.sv
// Interrupt queuing and exception entry for a 68000-style core. Each request
// is taken on s_valid/s_ready and answered on m_valid/m_ready: a raise, a
// status register write or a stack pointer write gives one result, and an
// accepted service gives three (PC push at A7+2, old SR push at A7, vector
// fetch at vector*4), the last flagged by last_result. A microprogram runs
// one request at a time: fetch, one execute step, then one step per result,
// and each result step holds while the result side stalls. The next request
// is taken while the final result still waits in the output register.
// Vectors sit in one memory of 7 x QUEUE_DEPTH bytes; no clearing pass is
// needed after reset.
module m68k_interrupt_entry_unit_core
    import m68kie_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    upc_t      upc_reg, upc_next;
    in_item_t  in_reg, in_next;
    logic [15:0] sr_reg, sr_next;
    logic [31:0] asp_reg, asp_next;
    logic [31:0] isp_reg, isp_next;
    logic [15:0] old_sr_reg, old_sr_next;
    logic      ovf_reg, ovf_next;
    logic      took_reg, took_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    ucode_t    uw;
    q_ctrl_t   q_ctrl;
    q_stat_t   q_stat;
    logic [7:0] pop_vector;
    logic      in_fire;
    logic      out_free;
    logic      stall;
    logic      took_now;
    out_item_t out_word;

    assign uw = ucode_rom(upc_reg);
    assign s_ready = (uw.seq == SQ_DISPATCH);
    assign in_fire = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign stall = (uw.emit != EM_NONE) && !out_free;

    assign took_now = (uw.exec == EX_SERVICE) && q_stat.top_valid
                      && ((q_stat.top_level == LevelNmi)
                          || (q_stat.top_level > sr_reg[SrMaskLsb +: 3]));

    always_comb begin
        q_ctrl.push = (uw.exec == EX_RAISE) && (in_reg.irq_level != 3'd0);
        q_ctrl.pop = took_now;
        q_ctrl.level = in_reg.irq_level;
        q_ctrl.push_vector = in_reg.vector_number;
    end

    m68kie_queues #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queues (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (q_ctrl),
        .stat      (q_stat),
        .pop_vector(pop_vector)
    );

    // Sequencer.
    always_comb begin
        case (uw.seq)
            SQ_DISPATCH: upc_next = in_fire ? uw.target + upc_t'(s_data.opcode) : upc_reg;
            SQ_BR_TOOK:  upc_next = took_now ? uw.target + upc_t'(1) : uw.target;
            SQ_GOTO:     upc_next = stall ? upc_reg : uw.target;
            default:     upc_next = UpcFetch;
        endcase
    end

    // Execute datapath.
    always_comb begin
        in_next = in_reg;
        sr_next = sr_reg;
        asp_next = asp_reg;
        isp_next = isp_reg;
        old_sr_next = old_sr_reg;
        ovf_next = ovf_reg;
        took_next = took_reg;

        if (in_fire) begin
            in_next = s_data;
            ovf_next = 1'b0;
            took_next = 1'b0;
        end

        case (uw.exec)
            EX_RAISE: begin
                ovf_next = q_ctrl.push && q_stat.push_full;
            end
            EX_SERVICE: begin
                took_next = took_now;
                if (took_now) begin
                    old_sr_next = sr_reg;
                    sr_next = (sr_reg & ~SrMaskBits)
                              | {5'd0, q_stat.top_level, 8'd0} | SrSupervisor;
                    // Entering supervisor mode from user mode swaps the stacks
                    // before the frame is pushed.
                    if (sr_reg[SrSBit]) begin
                        asp_next = asp_reg - FrameSize;
                    end else begin
                        asp_next = isp_reg - FrameSize;
                        isp_next = asp_reg;
                    end
                end
            end
            EX_WR_SR: begin
                sr_next = in_reg.data_word[15:0];
                if (in_reg.data_word[SrSBit] != sr_reg[SrSBit]) begin
                    asp_next = isp_reg;
                    isp_next = asp_reg;
                end
            end
            EX_WR_SP: begin
                asp_next = in_reg.data_word;
            end
            default: begin
            end
        endcase
    end

    // Result assembly.
    always_comb begin
        out_word.access_kind = AccNone;
        out_word.access_address = '0;
        out_word.access_data = '0;
        case (uw.emit)
            EM_PC: begin
                out_word.access_kind = AccWrite32;
                out_word.access_address = asp_reg + PcSlotOffset;
                out_word.access_data = in_reg.data_word;
            end
            EM_SR: begin
                out_word.access_kind = AccWrite16;
                out_word.access_address = asp_reg;
                out_word.access_data = {16'd0, old_sr_reg};
            end
            EM_VEC: begin
                out_word.access_kind = AccRead32;
                out_word.access_address = {22'd0, pop_vector, 2'b00};
            end
            default: begin
            end
        endcase
        out_word.status_out = sr_reg;
        out_word.stack_pointer_out = asp_reg;
        out_word.interrupt_pending = q_stat.any_pending;
        out_word.queue_overflow = ovf_reg;
        out_word.accepted = took_reg;
        out_word.last_result = uw.last;

        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        if ((uw.emit != EM_NONE) && out_free) begin
            m_valid_next = 1'b1;
            m_data_next = out_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UpcFetch;
            sr_reg <= SrResetValue;
            asp_reg <= '0;
            isp_reg <= '0;
            ovf_reg <= 1'b0;
            took_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            sr_reg <= sr_next;
            asp_reg <= asp_next;
            isp_reg <= isp_next;
            ovf_reg <= ovf_next;
            took_reg <= took_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next;
        old_sr_reg <= old_sr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

`ifndef NO_ASSERTIONS
    // A taken interrupt always runs in supervisor mode.
    a_took_supervisor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.status_out[SrSBit])
        else $error("accepted interrupt without supervisor bit");

    // The vector fetch closes the exception frame.
    a_vector_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.access_kind == AccRead32) |-> m_data.last_result)
        else $error("vector fetch not flagged as last result");

    // No new request is taken while a frame is still being emitted.
    a_no_fetch_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_result |-> !s_ready)
        else $error("request accepted in the middle of an exception frame");

    // The old SR lands at the lowered stack pointer.
    a_sr_at_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.access_kind == AccWrite16)
        |-> m_data.access_address == m_data.stack_pointer_out)
        else $error("old status word not pushed at the stack pointer");

    // A single request cannot both drop a raise and take an interrupt.
    a_ovf_excl_took: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.queue_overflow && m_data.accepted))
        else $error("overflow and acceptance flagged together");
`endif

endmodule

>>> hw/rtl/m68kie_ram.sv
module m68kie_ram
    import m68kie_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = 56,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/m68kie_queues.sv
module m68kie_queues
    import m68kie_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  q_ctrl_t    ctrl,
    output q_stat_t    stat,
    output logic [7:0] pop_vector
);

    localparam int FillW = $clog2(QUEUE_DEPTH + 1);
    localparam int SlotW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SumW = FillW + 1;
    localparam int MemDepth = LevelCount * QUEUE_DEPTH;
    localparam int AddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;

    logic [FillW-1:0] fill_reg [LevelCount];
    logic [SlotW-1:0] slot_reg [LevelCount];

    logic [LevelCount-1:0] nonempty;
    logic [2:0]            top_level;
    logic [2:0]            idx;
    logic [FillW-1:0]      cur_fill;
    logic [SlotW-1:0]      cur_slot;
    logic [SumW-1:0]       slot_sum;
    logic [SlotW-1:0]      wr_slot;
    logic [SlotW-1:0]      rd_slot_next;
    logic                  full;
    logic                  do_write;
    logic [AddrW-1:0]      mem_addr;

    always_comb begin
        top_level = 3'd0;
        for (int q = 0; q < LevelCount; q++) begin
            nonempty[q] = (fill_reg[q] != '0);
            if (nonempty[q]) begin
                top_level = 3'(q + 1);
            end
        end
    end

    // One queue is addressed at a time: the highest pending level when
    // popping, otherwise the level of the raise.
    always_comb begin
        if (ctrl.pop) begin
            idx = top_level - 3'd1;
        end else if (ctrl.level != 3'd0) begin
            idx = ctrl.level - 3'd1;
        end else begin
            idx = 3'd0;
        end
        cur_fill = fill_reg[idx];
        cur_slot = slot_reg[idx];
        full = (cur_fill == FillW'(QUEUE_DEPTH));

        slot_sum = SumW'(cur_slot) + SumW'(cur_fill);
        if (slot_sum >= SumW'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - SumW'(QUEUE_DEPTH);
        end
        wr_slot = SlotW'(slot_sum);

        if (cur_slot == SlotW'(QUEUE_DEPTH - 1)) begin
            rd_slot_next = '0;
        end else begin
            rd_slot_next = cur_slot + SlotW'(1);
        end

        do_write = ctrl.push && !full;
        mem_addr = AddrW'(int'(idx) * QUEUE_DEPTH
                          + int'(ctrl.pop ? cur_slot : wr_slot));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < LevelCount; q++) begin
                fill_reg[q] <= '0;
                slot_reg[q] <= '0;
            end
        end else begin
            for (int q = 0; q < LevelCount; q++) begin
                if (idx == 3'(q)) begin
                    if (do_write) begin
                        fill_reg[q] <= cur_fill + FillW'(1);
                    end else if (ctrl.pop) begin
                        fill_reg[q] <= cur_fill - FillW'(1);
                        slot_reg[q] <= rd_slot_next;
                    end
                end
            end
        end
    end

    m68kie_ram #(
        .Width(8),
        .Depth(MemDepth)
    ) u_store (
        .aclk (aclk),
        .we   (do_write),
        .waddr(mem_addr),
        .wdata(ctrl.push_vector),
        .re   (ctrl.pop),
        .raddr(mem_addr),
        .rdata(pop_vector)
    );

    assign stat.any_pending = |nonempty;
    assign stat.top_valid = |nonempty;
    assign stat.top_level = top_level;
    assign stat.push_full = full;

endmodule
